/* rtl/core/ufifo_pkg.sv */
package ufifo_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OCC_W   = 5;

    typedef enum logic
    {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_PUSHED = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_POPPED = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    typedef struct packed
    {
        cmd_t                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } in_word_t;

    typedef struct packed
    {
        status_t                    status;
        logic signed [VALUE_W-1:0]  popped_value;
        logic [OCC_W-1:0]           occupancy;
    } out_word_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_EMIT
    } eng_state_t;

endpackage

/* rtl/core/ufifo_queue.sv */
module ufifo_queue #(
    parameter type word_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  word_t wr_data,
    input  logic  pop,
    output logic  empty,
    output word_t rd_data
);

    localparam logic [1:0] QFULL = 2'd2;

    word_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == QFULL);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/ufifo_engine.sv */
module ufifo_engine #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_empty,
    input  ufifo_pkg::in_word_t  in_word,
    output logic                 in_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output ufifo_pkg::out_word_t res_word
);

    import ufifo_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic signed [VALUE_W-1:0] entry_mem [DEPTH];
    logic signed [VALUE_W-1:0] mem_q_reg;

    eng_state_t       state_reg;
    eng_state_t       state_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] scan_addr_reg;
    logic [IDX_W-1:0] scan_addr_next;
    logic [CNT_W-1:0] scan_left_reg;
    logic [CNT_W-1:0] scan_left_next;
    logic             cmp_valid_reg;
    logic             cmp_valid_next;
    in_word_t         cur_reg;
    in_word_t         cur_next;
    out_word_t        res_reg;
    out_word_t        res_next;

    logic                      mem_wr;
    logic signed [VALUE_W-1:0] mem_wr_data;
    logic                      mem_rd;
    logic [IDX_W-1:0]          mem_rd_addr;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    assign res_word = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        cmp_valid_next = cmp_valid_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        in_pop         = 1'b0;
        res_push       = 1'b0;
        mem_wr         = 1'b0;
        mem_wr_data    = cur_reg.value;
        mem_rd         = 1'b0;
        mem_rd_addr    = scan_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!in_empty)
                begin
                    in_pop   = 1'b1;
                    cur_next = in_word;
                    if (in_word.cmd == CMD_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next = '{status: ST_EMPTY, popped_value: '0,
                                         occupancy: OCC_W'(count_reg)};
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            mem_rd      = 1'b1;
                            mem_rd_addr = head_reg;
                            state_next  = S_POP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // nothing to compare against: append at once
                        mem_wr      = 1'b1;
                        mem_wr_data = in_word.value;
                        tail_next   = next_idx(tail_reg);
                        count_next  = CNT_W'(count_reg + 1'b1);
                        res_next    = '{status: ST_PUSHED, popped_value: '0,
                                        occupancy: OCC_W'(count_reg + 1'b1)};
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        scan_addr_next = head_reg;
                        scan_left_next = count_reg;
                        cmp_valid_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // compare the entry read last cycle, issue the next read
                priority if (cmp_valid_reg && (mem_q_reg == cur_reg.value))
                begin
                    cmp_valid_next = 1'b0;
                    res_next = '{status: ST_DUP, popped_value: '0,
                                 occupancy: OCC_W'(count_reg)};
                    state_next = S_EMIT;
                end
                else if (scan_left_reg == '0)
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_EMIT;
                    if (count_reg == FULL_CNT)
                    begin
                        res_next = '{status: ST_FULL, popped_value: '0,
                                     occupancy: OCC_W'(count_reg)};
                    end
                    else
                    begin
                        mem_wr     = 1'b1;
                        tail_next  = next_idx(tail_reg);
                        count_next = CNT_W'(count_reg + 1'b1);
                        res_next   = '{status: ST_PUSHED, popped_value: '0,
                                       occupancy: OCC_W'(count_reg + 1'b1)};
                    end
                end
                else
                begin
                    mem_rd         = 1'b1;
                    scan_addr_next = next_idx(scan_addr_reg);
                    scan_left_next = CNT_W'(scan_left_reg - 1'b1);
                    cmp_valid_next = 1'b1;
                end
            end

            S_POP:
            begin
                head_next  = next_idx(head_reg);
                count_next = CNT_W'(count_reg - 1'b1);
                res_next   = '{status: ST_POPPED, popped_value: mem_q_reg,
                               occupancy: OCC_W'(count_reg - 1'b1)};
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // hold the result until the output queue has room
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            scan_left_reg <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            scan_left_reg <= scan_left_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            entry_mem[tail_reg] <= mem_wr_data;
        end
        if (mem_rd)
        begin
            mem_q_reg <= entry_mem[mem_rd_addr];
        end
    end

endmodule

/* rtl/core/unique_entry_fifo.sv */
// Channel   Ports                       Handshake
// input     push, full, wr_data         word taken when push && !full
// result    pop, empty, rd_data         word taken when pop && !empty
//
// A push into a queue holding entries keeps the engine busy while it scans them:
// the held entries are read one per cycle through the single read port of the
// entry memory to check for a duplicate; a hit ends the scan early, and a push
// into an empty queue skips the scan. A pop on an empty queue skips S_POP.
// Two-word queues on both sides let the input and result sides stall apart.
// rst_n clears indices and counts; entry contents need no clearing.
module unique_entry_fifo #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ufifo_pkg::in_word_t  wr_data,
    input  logic                 pop,
    output logic                 empty,
    output ufifo_pkg::out_word_t rd_data
);

    import ufifo_pkg::*;

    logic      front_empty;
    logic      front_pop;
    in_word_t  front_word;
    logic      res_full;
    logic      res_push;
    out_word_t res_word;

    ufifo_queue #(
        .word_t (in_word_t)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_data (wr_data),
        .pop     (front_pop),
        .empty   (front_empty),
        .rd_data (front_word)
    );

    ufifo_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (front_empty),
        .in_word  (front_word),
        .in_pop   (front_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_word (res_word)
    );

    ufifo_queue #(
        .word_t (out_word_t)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .full    (res_full),
        .wr_data (res_word),
        .pop     (pop),
        .empty   (empty),
        .rd_data (rd_data)
    );

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full output queue");

    a_front_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        front_pop |-> !front_empty)
        else $error("engine took a word from empty input queue");

    a_zero_unless_popped: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res_word.status != ST_POPPED)) |-> (res_word.popped_value == '0))
        else $error("nonzero value on a result that is not a pop");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res_word.status == ST_FULL)) |-> (res_word.occupancy == OCC_W'(DEPTH)))
        else $error("full rejection with queue not full");

    a_empty_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res_word.status == ST_EMPTY)) |-> (res_word.occupancy == '0))
        else $error("empty error with entries held");

endmodule

/* sim/unique_entry_fifo_test.sv */
`timescale 1ns / 1ps

module unique_entry_fifo_test;

    import ufifo_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 20;
    localparam int unsigned HOLD_CYCLES  = 300;

    // Shadow copy of the ring: tracks held values and queues the reply each command earns.
    class dedup_ring_tracker;
        logic signed [VALUE_W-1:0] slots [DEPTH];
        int unsigned               head_slot;
        int unsigned               tail_slot;
        int unsigned               held;
        out_word_t                 pending_replies [$];
        int unsigned               mismatches;

        function new();
            head_slot  = 0;
            tail_slot  = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        function bit holds_value(logic signed [VALUE_W-1:0] v);
            for (int unsigned k = 0; k < held; k++)
            begin
                if (slots[(head_slot + k) % DEPTH] == v)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic signed [VALUE_W-1:0] held_value(int unsigned k);
            return slots[(head_slot + k) % DEPTH];
        endfunction

        function void apply_command(in_word_t w);
            out_word_t reply;
            reply = '0;
            if (w.cmd == CMD_PUSH)
            begin
                // duplicate check wins over full
                if (holds_value(w.value))
                    reply.status = ST_DUP;
                else if (held == DEPTH)
                    reply.status = ST_FULL;
                else
                begin
                    slots[tail_slot] = w.value;
                    tail_slot        = (tail_slot + 1) % DEPTH;
                    held++;
                    reply.status = ST_PUSHED;
                end
            end
            else
            begin
                if (held == 0)
                    reply.status = ST_EMPTY;
                else
                begin
                    reply.popped_value = slots[head_slot];
                    head_slot          = (head_slot + 1) % DEPTH;
                    held--;
                    reply.status = ST_POPPED;
                end
            end
            reply.occupancy = OCC_W'(held);
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(out_word_t got);
            out_word_t want;
            if (pending_replies.size() == 0)
            begin
                $error({"result word with no command waiting: ",
                        "status %0d, popped_value %0d, occupancy %0d"},
                       got.status, got.popped_value, got.occupancy);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.popped_value !== want.popped_value)
            begin
                $error("popped_value: expected %0d, actual %0d",
                       want.popped_value, got.popped_value);
                mismatches++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
                mismatches++;
            end
        endfunction
    endclass

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    logic      full;
    logic      empty;
    in_word_t  wr_data = '0;
    out_word_t rd_data;

    int unsigned       idle_cycles = 0;
    dedup_ring_tracker tracker     = new();

    unique_entry_fifo #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_data (wr_data),
        .pop     (pop),
        .empty   (empty),
        .rd_data (rd_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Abort when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic in_word_t make_word(cmd_t cmd, logic signed [VALUE_W-1:0] value);
        in_word_t w;
        w.cmd   = cmd;
        w.value = value;
        return w;
    endfunction

    // Hold push high until the word is taken; leave it high for the next word.
    task automatic send_word(in_word_t w, bit steady);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        wr_data <= w;
        do
            @(posedge clk);
        while (full !== 1'b0);
        tracker.apply_command(w);
    endtask

    task automatic send_random_word(int unsigned push_pct, bit steady);
        in_word_t    w;
        int unsigned pick;
        int          near_zero;
        w.value = $urandom;
        if ($urandom_range(1, 100) > push_pct)
            w.cmd = CMD_POP;
        else
        begin
            w.cmd = CMD_PUSH;
            pick  = $urandom_range(0, 99);
            if (pick < 35 && tracker.held > 0)
                w.value = tracker.held_value($urandom_range(0, tracker.held - 1));
            else if (pick < 70)
            begin
                near_zero = int'($urandom_range(0, 40)) - 20;
                w.value   = near_zero;
            end
            else if (pick < 76)
            begin
                case ($urandom_range(0, 3))
                    0: w.value = 32'h8000_0000;
                    1: w.value = 32'h7FFF_FFFF;
                    2: w.value = 32'h0000_0000;
                    default: w.value = 32'hFFFF_FFFF;
                endcase
            end
        end
        send_word(w, steady);
    endtask

    initial
    begin : result_side
        int unsigned gap;
        int unsigned taken;
        bit          steady;
        taken  = 0;
        steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 32 == 0)
                steady = ($urandom_range(0, 3) == 0);
            gap = steady ? 0 : $urandom_range(0, 15);
            // long hold-off so the block backs up and stalls its input
            if (taken == 400 || taken == 1300)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty !== 1'b0);
            tracker.check_reply(rd_data);
            taken++;
        end
    end

    initial
    begin : stimulus
        in_word_t    directed [$];
        int unsigned push_pct;
        bit          steady;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pop on empty, extremes, duplicate, then fill to the brim
        directed.push_back(make_word(CMD_POP,  32'h1234_5678));
        directed.push_back(make_word(CMD_PUSH, 32'h8000_0000));
        directed.push_back(make_word(CMD_PUSH, 32'h7FFF_FFFF));
        directed.push_back(make_word(CMD_PUSH, 32'h8000_0000));
        directed.push_back(make_word(CMD_POP,  32'hFFFF_FFFF));
        directed.push_back(make_word(CMD_PUSH, 32'h0000_0000));
        directed.push_back(make_word(CMD_PUSH, 32'hFFFF_FFFF));
        for (int k = 0; k < 13; k++)
            directed.push_back(make_word(CMD_PUSH, 32'(1) << k));
        // full with a new value, then a duplicate while full
        directed.push_back(make_word(CMD_PUSH, 32'h5555_5555));
        directed.push_back(make_word(CMD_PUSH, 32'h0000_0000));
        directed.push_back(make_word(CMD_POP,  32'h0000_0000));
        foreach (directed[i])
            send_word(directed[i], 1'b0);

        push_pct = 50;
        steady   = 1'b0;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            // bias bursts toward filling, draining, or churning
            if (n % 24 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
                steady = ($urandom_range(0, 3) == 0);
            end
            send_random_word(push_pct, steady);
        end
        push <= 1'b0;

        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
